// ===== rtl/pwog_pkg.sv =====
// Shared types, constants and register codes for the per-class outlier gate.
`timescale 1ns / 1ps
package pwog_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = $clog2(NUM_CLASSES);
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 6;
  localparam int DIV_STEPS   = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MERGE_COUNT = 3'd0;
  localparam logic [2:0] REG_SLOW_COUNT  = 3'd1;
  localparam logic [2:0] REG_Z_LIMIT     = 3'd2;
  localparam logic [2:0] REG_SPREAD_EARLY = 3'd3;
  localparam logic [2:0] REG_SPREAD_LATE = 3'd4;

  // Reset values of the registers
  localparam logic [7:0]  RST_MERGE_COUNT = 8'd20;
  localparam logic [7:0]  RST_SLOW_COUNT  = 8'd3;
  localparam logic [15:0] RST_Z_LIMIT     = 16'd640;
  localparam logic [46:0] RST_SPREAD_EARLY = 47'd214748365;
  localparam logic [46:0] RST_SPREAD_LATE = 47'd4294967296;

  // Result status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_FIRST    = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_OUTLIER  = 3'd3;
  localparam logic [2:0] ST_RESET    = 3'd4;

  typedef struct packed {
    logic [7:0]         target_class;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               service_accepts;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               slow_request;
    logic               normal_request;
    logic               snapshot_valid;
    logic [1:0]         class_out;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [62:0]        sum_xx;
    logic signed [63:0] sum_xy;
    logic signed [63:0] sum_yx;
    logic [62:0]        sum_yy;
    logic [15:0]        obs_count;
  } out_t;

  // Classified item as it travels from the front to the back
  typedef struct packed {
    logic               ignored;
    logic [IDX_W-1:0]   idx;
    logic [1:0]         cls2;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ok;
  } job_t;

  typedef struct packed {
    logic [7:0]  merge_count;
    logic [7:0]  slow_count;
    logic [15:0] z_limit;
    logic [46:0] spread_early;
    logic [46:0] spread_late;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/pwog_front.sv =====
// Front end: takes items on the command port and classifies them for the queue.
`timescale 1ns / 1ps
module pwog_front (
  input  logic          start,
  input  pwog_pkg::in_t item,
  input  pwog_pkg::qstat_t qstat,
  output logic          busy,
  output logic          push,
  output pwog_pkg::job_t job
);
  import pwog_pkg::*;

  logic cls_ok;

  // Stall the sender while the queue is full
  assign busy = qstat.full;
  assign push = start && !qstat.full;

  // Classify: only classes 1 to NUM_CLASSES are processed
  assign cls_ok = (item.target_class >= 8'd1) &&
                  (item.target_class <= 8'(NUM_CLASSES));

  always_comb begin
    job.ignored = !cls_ok;
    job.idx     = IDX_W'(item.target_class - 8'd1);
    job.cls2    = item.target_class[1:0];
    job.x       = item.pos_x;
    job.y       = item.pos_y;
    job.ok      = item.service_accepts;
  end

endmodule

// ===== rtl/pwog_queue.sv =====
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module pwog_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pwog_pkg::job_t    push_data,
  input  logic              pop,
  output pwog_pkg::job_t    pop_data,
  output pwog_pkg::qstat_t  qstat
);
  import pwog_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign qstat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_data    = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/pwog_back.sv =====
// Back end: per-class state, z test, mean and sum update, requests and result.
`timescale 1ns / 1ps
module pwog_back (
  input  logic             clk,
  input  logic             rst,
  input  pwog_pkg::cfg_t   cfg,
  input  pwog_pkg::qstat_t qstat,
  input  pwog_pkg::job_t   q_data,
  output logic             q_pop,
  output logic             done,
  output pwog_pkg::out_t   result
);
  import pwog_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ZT, S_ZC, S_DINIT, S_DIV, S_MEAN, S_SUM, S_LIM, S_REQ, S_OUT
  } state_t;

  localparam logic [63:0] BIAS64 = 64'h8000_0000_0000_0000;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = v[32] ? 33'(-v) : 33'(v);
    return n[31:0];
  endfunction

  function automatic logic [62:0] sat_sq(input logic [62:0] s, input logic [63:0] p);
    logic [64:0] t;
    t = {2'b00, s} + {1'b0, p};
    return (t[64:63] != 2'b00) ? '1 : t[62:0];
  endfunction

  function automatic logic [63:0] sat_cross(input logic [63:0] s, input logic [63:0] p,
                                            input logic neg);
    logic [63:0] u;
    logic [64:0] t;
    u = s ^ BIAS64;
    if (neg) begin
      t = {1'b0, u} - {1'b0, p};
      u = t[64] ? '0 : t[63:0];
    end else begin
      t = {1'b0, u} + {1'b0, p};
      u = t[64] ? '1 : t[63:0];
    end
    return u ^ BIAS64;
  endfunction

  state_t state;

  // Per-class state
  logic [COUNT_BITS-1:0] cnt_a   [NUM_CLASSES];
  logic signed [31:0]    mx_a    [NUM_CLASSES];
  logic signed [31:0]    my_a    [NUM_CLASSES];
  logic [62:0]           sxx_a   [NUM_CLASSES];
  logic [63:0]           sxy_a   [NUM_CLASSES];
  logic [63:0]           syx_a   [NUM_CLASSES];
  logic [62:0]           syy_a   [NUM_CLASSES];
  logic                  sent_a  [NUM_CLASSES];
  logic                  search_active;
  logic [1:0]            search_class;

  // Working registers for the item in hand
  job_t                  job;
  logic [COUNT_BITS-1:0] cnt;
  logic signed [31:0]    mx;
  logic signed [31:0]    my;
  logic [62:0]           s0;
  logic [63:0]           s1;
  logic [63:0]           s2;
  logic [62:0]           s3;
  logic signed [32:0]    dx;
  logic signed [32:0]    dy;
  logic signed [32:0]    ex;
  logic signed [32:0]    ey;
  logic [31:0]           zsq;
  logic [63:0]           dsq;
  logic [95:0]           acc;
  logic                  out_x;
  logic [2:0]            step;
  logic [2:0]            status;
  logic                  snap_hit;
  logic                  slow;
  logic                  normal;
  logic                  snap;

  // Divider lanes: dx / k, dy / k and k % m
  logic [31:0]           dvd_x;
  logic [31:0]           dvd_y;
  logic [31:0]           dvd_m;
  logic [COUNT_BITS-1:0] rem_x;
  logic [COUNT_BITS-1:0] rem_y;
  logic [7:0]            rem_m;
  logic [DCNT_W-1:0]     div_cnt;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] p;

  logic [7:0]            m_eff;
  logic [COUNT_BITS-1:0] k_next;
  logic [COUNT_BITS:0]   tx;
  logic [COUNT_BITS:0]   ty;
  logic [8:0]            tm;
  logic                  gx;
  logic                  gy;
  logic                  gm;
  logic [COUNT_BITS-1:0] rem_x_next;
  logic [COUNT_BITS-1:0] rem_y_next;
  logic [7:0]            rem_m_next;
  logic signed [32:0]    nx;
  logic signed [32:0]    ny;
  logic [46:0]           lim;
  logic                  slow_now;
  logic                  sa_after;
  logic [1:0]            sc_after;
  logic                  normal_now;

  assign q_pop  = (state == S_IDLE) && !qstat.empty;
  assign m_eff  = (cfg.merge_count == 8'd0) ? 8'd1 : cfg.merge_count;
  assign k_next = (cnt == '1) ? cnt : cnt + 1'b1;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ZT: begin
        case (step)
          3'd0:    begin mul_a = mag33(dx); mul_b = mag33(dx); end
          3'd1:    begin mul_a = zsq; mul_b = s0[31:0]; end
          3'd2:    begin mul_a = zsq; mul_b = {1'b0, s0[62:32]}; end
          3'd4:    begin mul_a = mag33(dy); mul_b = mag33(dy); end
          3'd5:    begin mul_a = zsq; mul_b = s3[31:0]; end
          3'd6:    begin mul_a = zsq; mul_b = {1'b0, s3[62:32]}; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SUM: begin
        case (step)
          3'd0:    begin mul_a = mag33(dx); mul_b = mag33(ex); end
          3'd1:    begin mul_a = mag33(dx); mul_b = mag33(ey); end
          3'd2:    begin mul_a = mag33(dy); mul_b = mag33(ex); end
          3'd3:    begin mul_a = mag33(dy); mul_b = mag33(ey); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // One restoring step for each divider lane
  always_comb begin
    tx = {rem_x, dvd_x[31]};
    ty = {rem_y, dvd_y[31]};
    tm = {rem_m, dvd_m[31]};
    gx = tx >= {1'b0, cnt};
    gy = ty >= {1'b0, cnt};
    gm = tm >= {1'b0, m_eff};
    rem_x_next = gx ? COUNT_BITS'(tx - {1'b0, cnt}) : COUNT_BITS'(tx);
    rem_y_next = gy ? COUNT_BITS'(ty - {1'b0, cnt}) : COUNT_BITS'(ty);
    rem_m_next = gm ? 8'(tm - {1'b0, m_eff}) : 8'(tm);
  end

  // New mean from the truncated quotients
  always_comb begin
    nx = {mx[31], mx} + (dx[32] ? -$signed({1'b0, dvd_x}) : $signed({1'b0, dvd_x}));
    ny = {my[31], my} + (dy[32] ? -$signed({1'b0, dvd_y}) : $signed({1'b0, dvd_y}));
  end

  // Spread limit for the count stage, and request decisions
  always_comb begin
    lim        = (cnt <= COUNT_BITS'(m_eff)) ? cfg.spread_early : cfg.spread_late;
    slow_now   = !sent_a[job.idx] && (cnt >= COUNT_BITS'(cfg.slow_count));
    sa_after   = (slow_now && job.ok) ? 1'b1 : search_active;
    sc_after   = (slow_now && job.ok) ? job.cls2 : search_class;
    normal_now = snap_hit && sa_after && (sc_after == job.cls2);
  end

  // Sequencer, per-class state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      search_active <= 1'b0;
      search_class  <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_a[i]  <= '0;
        mx_a[i]   <= '0;
        my_a[i]   <= '0;
        sxx_a[i]  <= '0;
        sxy_a[i]  <= '0;
        syx_a[i]  <= '0;
        syy_a[i]  <= '0;
        sent_a[i] <= 1'b0;
      end
    end else begin
      done <= (state == S_OUT);
      case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            job    <= q_data;
            slow   <= 1'b0;
            normal <= 1'b0;
            snap   <= 1'b0;
            state  <= S_LOAD;
          end
        end
        // Fetch the class state and classify the step
        S_LOAD: begin
          dx   <= {job.x[31], job.x} - {mx_a[job.idx][31], mx_a[job.idx]};
          dy   <= {job.y[31], job.y} - {my_a[job.idx][31], my_a[job.idx]};
          zsq  <= cfg.z_limit * cfg.z_limit;
          step <= '0;
          if (!job.ignored && cnt_a[job.idx] == '0) begin
            mx  <= job.x;
            my  <= job.y;
            s0  <= '0;
            s1  <= '0;
            s2  <= '0;
            s3  <= '0;
            cnt <= COUNT_BITS'(1);
          end else begin
            cnt <= cnt_a[job.idx];
            mx  <= mx_a[job.idx];
            my  <= my_a[job.idx];
            s0  <= sxx_a[job.idx];
            s1  <= sxy_a[job.idx];
            s2  <= syx_a[job.idx];
            s3  <= syy_a[job.idx];
          end
          if (job.ignored) begin
            status <= ST_IGNORED;
            state  <= S_OUT;
          end else if (cnt_a[job.idx] == '0) begin
            status   <= ST_FIRST;
            snap_hit <= (m_eff == 8'd1);
            state    <= S_REQ;
          end else if (cnt_a[job.idx] >= COUNT_BITS'(m_eff)) begin
            status <= ST_ACCEPTED;
            state  <= S_ZT;
          end else begin
            status <= ST_ACCEPTED;
            state  <= S_DINIT;
          end
        end
        // Two-sided z test: d^2 * 2^16 against z^2 * M2 on each axis
        S_ZT: begin
          step <= step + 1'b1;
          case (step)
            3'd1, 3'd5: dsq <= p;
            3'd2, 3'd6: acc <= {32'b0, p};
            3'd3, 3'd7: acc <= acc + {p, 32'b0};
            3'd4:       out_x <= ({16'b0, dsq, 16'b0} > acc);
            default:    acc <= acc;
          endcase
          if (step == 3'd7) begin
            state <= S_ZC;
          end
        end
        S_ZC: begin
          if (out_x || ({16'b0, dsq, 16'b0} > acc)) begin
            status <= ST_OUTLIER;
            state  <= S_OUT;
          end else begin
            state <= S_DINIT;
          end
        end
        // Count the observation and load the divider
        S_DINIT: begin
          cnt     <= k_next;
          dvd_x   <= mag33(dx);
          dvd_y   <= mag33(dy);
          dvd_m   <= 32'(k_next);
          rem_x   <= '0;
          rem_y   <= '0;
          rem_m   <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          dvd_x   <= {dvd_x[30:0], gx};
          dvd_y   <= {dvd_y[30:0], gy};
          dvd_m   <= {dvd_m[30:0], gm};
          rem_x   <= rem_x_next;
          rem_y   <= rem_y_next;
          rem_m   <= rem_m_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mx       <= nx[31:0];
          my       <= ny[31:0];
          ex       <= {job.x[31], job.x} - nx;
          ey       <= {job.y[31], job.y} - ny;
          snap_hit <= (rem_m == 8'd0);
          step     <= '0;
          state    <= S_SUM;
        end
        // Accumulate the four products, one a cycle
        S_SUM: begin
          step <= step + 1'b1;
          case (step)
            3'd1:    s0 <= sat_sq(s0, p);
            3'd2:    s1 <= sat_cross(s1, p, dx[32] ^ ey[32]);
            3'd3:    s2 <= sat_cross(s2, p, dy[32] ^ ex[32]);
            3'd4:    s3 <= sat_sq(s3, p);
            default: s0 <= s0;
          endcase
          if (step == 3'd4) begin
            state <= S_LIM;
          end
        end
        // Drop the class when its spread runs past the limit
        S_LIM: begin
          if (s0 > {16'b0, lim} || s3 > {16'b0, lim}) begin
            cnt    <= '0;
            mx     <= '0;
            my     <= '0;
            s0     <= '0;
            s1     <= '0;
            s2     <= '0;
            s3     <= '0;
            status <= ST_RESET;
            state  <= S_OUT;
          end else begin
            state <= S_REQ;
          end
        end
        S_REQ: begin
          slow   <= slow_now;
          snap   <= snap_hit;
          normal <= normal_now;
          if (slow_now && job.ok) begin
            sent_a[job.idx] <= 1'b1;
          end
          search_active <= (normal_now && job.ok) ? 1'b0 : sa_after;
          search_class  <= sc_after;
          state         <= S_OUT;
        end
        // Write back and present the result for one cycle
        S_OUT: begin
          if (!job.ignored) begin
            cnt_a[job.idx] <= cnt;
            mx_a[job.idx]  <= mx;
            my_a[job.idx]  <= my;
            sxx_a[job.idx] <= s0;
            sxy_a[job.idx] <= s1;
            syx_a[job.idx] <= s2;
            syy_a[job.idx] <= s3;
          end
          if (job.ignored) begin
            result <= '0;
          end else begin
            result.status         <= status;
            result.slow_request   <= slow;
            result.normal_request <= normal;
            result.snapshot_valid <= snap;
            result.class_out      <= job.cls2;
            result.mean_x         <= mx;
            result.mean_y         <= my;
            result.sum_xx         <= s0;
            result.sum_xy         <= s1;
            result.sum_yx         <= s2;
            result.sum_yy         <= s3;
            result.obs_count      <= 16'(cnt);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/per_class_welford_outlier_gate_unit.sv =====
// Top level: configuration registers, front end, item queue and back end.
//
// Usage: a detection item is offered on item with start high; it is taken at
// a rising edge where start is high and busy is low. busy rises only while the
// two-entry queue between the front and back ends is full.
// Each item yields exactly one result on result, marked by done for a single
// cycle; the receiver must take it then, as it cannot stall the block.
// Path from acceptance to done, with the back end idle: an ignored class goes
// straight to the result, a first detection goes on to the requests, and an
// ordinary update runs the divider, the sum products and the spread limit, with
// the z test ahead of them once the class holds the merge count. The mean update
// uses the 32-step restoring divider, and the z test and four sum products share
// one 32x32 multiplier; the back end handles one item at a time.
// The APB port holds five registers at byte addresses 0, 8, 16, 24 and 32,
// 64 bits wide; write them only while no item is in flight.
// Synchronous reset restores the register defaults and clears every class
// state, the queue and the search flags; no clearing pass is needed.
`timescale 1ns / 1ps
module per_class_welford_outlier_gate_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  pwog_pkg::in_t               item,
  output logic                        busy,
  output logic                        done,
  output pwog_pkg::out_t              result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pwog_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import pwog_pkg::*;

  cfg_t   cfg;
  job_t   push_job;
  job_t   pop_job;
  qstat_t qstat;
  logic   push;
  logic   pop;
  logic   wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.merge_count  <= RST_MERGE_COUNT;
      cfg.slow_count   <= RST_SLOW_COUNT;
      cfg.z_limit      <= RST_Z_LIMIT;
      cfg.spread_early <= RST_SPREAD_EARLY;
      cfg.spread_late  <= RST_SPREAD_LATE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MERGE_COUNT:  cfg.merge_count  <= pwdata[7:0];
        REG_SLOW_COUNT:   cfg.slow_count   <= pwdata[7:0];
        REG_Z_LIMIT:      cfg.z_limit      <= pwdata[15:0];
        REG_SPREAD_EARLY: cfg.spread_early <= pwdata[46:0];
        REG_SPREAD_LATE:  cfg.spread_late  <= pwdata[46:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_MERGE_COUNT:  prdata = {56'b0, cfg.merge_count};
      REG_SLOW_COUNT:   prdata = {56'b0, cfg.slow_count};
      REG_Z_LIMIT:      prdata = {48'b0, cfg.z_limit};
      REG_SPREAD_EARLY: prdata = {17'b0, cfg.spread_early};
      REG_SPREAD_LATE:  prdata = {17'b0, cfg.spread_late};
      default:          prdata = '0;
    endcase
  end

  pwog_front u_front (
    .start (start),
    .item  (item),
    .qstat (qstat),
    .busy  (busy),
    .push  (push),
    .job   (push_job)
  );

  pwog_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .qstat     (qstat)
  );

  pwog_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .qstat  (qstat),
    .q_data (pop_job),
    .q_pop  (pop),
    .done   (done),
    .result (result)
  );

endmodule

// ===== rtl/pwog_checker.sv =====
// Port-level checks on the outlier gate, bound to the top level.
`timescale 1ns / 1ps
module pwog_checker (
  input logic           clk,
  input logic           rst,
  input logic           done,
  input pwog_pkg::out_t result
);
  import pwog_pkg::*;

  // Results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // No result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // An ignored item reports nothing
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_IGNORED) |->
      (result.obs_count == 16'd0 && !result.snapshot_valid && !result.slow_request))
    else $error("ignored item carries class data");

  // Outliers and class resets make no requests
  a_outlier_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_OUTLIER || result.status == ST_RESET)) |->
      (!result.slow_request && !result.normal_request && !result.snapshot_valid))
    else $error("request raised on outlier or class reset");

  // A normal request only comes with a snapshot
  a_normal_snap: assert property (@(posedge clk) disable iff (rst)
    (done && result.normal_request) |-> result.snapshot_valid)
    else $error("normal request without snapshot");

endmodule

bind per_class_welford_outlier_gate_unit pwog_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);

// ===== tb/per_class_welford_outlier_gate_unit_tb.sv =====
// Self-checking testbench for the per-class outlier gate, with driver, monitor and predictor.
`timescale 1ns / 1ps
module per_class_welford_outlier_gate_unit_tb;
  import pwog_pkg::*;

  localparam logic [63:0] MAX63  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BIAS64 = 64'h8000_0000_0000_0000;
  localparam logic [46:0] MAX47  = '1;
  localparam int          CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_t         item = '0;
  logic        busy, done, pready;
  out_t        result;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;

  per_class_welford_outlier_gate_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of registers and class state
  logic [7:0]  gate_merge = RST_MERGE_COUNT;
  logic [7:0]  gate_slow  = RST_SLOW_COUNT;
  logic [15:0] gate_z     = RST_Z_LIMIT;
  logic [46:0] gate_early = RST_SPREAD_EARLY;
  logic [46:0] gate_late  = RST_SPREAD_LATE;
  logic [15:0] cls_cnt [NUM_CLASSES];
  logic [31:0] cls_mx [NUM_CLASSES];
  logic [31:0] cls_my [NUM_CLASSES];
  logic [63:0] cls_sum [NUM_CLASSES*4];
  logic        cls_slow_sent [NUM_CLASSES];
  logic        srch_active;
  logic [1:0]  srch_class;

  in_t   pending_items [$];
  out_t  expected_results [$];
  int    errors = 0;
  int    send_idle = 0;
  int    cycles = 0;
  int    ctr_x [NUM_CLASSES];
  int    ctr_y [NUM_CLASSES];

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cls_cnt[c] = '0; cls_mx[c] = '0; cls_my[c] = '0; cls_slow_sent[c] = 1'b0;
      ctr_x[c] = 0; ctr_y[c] = 0;
    end
    for (int i = 0; i < NUM_CLASSES*4; i++) cls_sum[i] = '0;
    srch_active = 1'b0;
    srch_class = '0;
  end

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] umul(logic [63:0] a, logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  // Two-sided z test: d^2 * 2^16 > z^2 * M2
  function automatic bit z_exceeds(longint d, logic [63:0] m2);
    logic [63:0]  m, zz;
    logic [127:0] lhs, rhs;
    m = mag64(d);
    zz = 64'(gate_z) * 64'(gate_z);
    lhs = umul(m, m) << 16;
    rhs = umul(zz, m2);
    return lhs > rhs;
  endfunction

  function automatic logic [63:0] sq_accum(logic [63:0] s, longint a, longint b);
    logic [127:0] p;
    p = umul(mag64(a), mag64(b));
    if (p[127:64] != 0 || p[63:0] > MAX63 - s) return MAX63;
    return s + p[63:0];
  endfunction

  function automatic logic [63:0] cross_accum(logic [63:0] s, longint a, longint b);
    logic [127:0] p;
    logic [63:0]  u;
    bit           neg;
    u = s ^ BIAS64;
    neg = (a < 0) != (b < 0);
    p = umul(mag64(a), mag64(b));
    if (neg) begin
      if (p[127:64] != 0 || p[63:0] > u) u = '0;
      else u = u - p[63:0];
    end else begin
      if (p[127:64] != 0 || p[63:0] > ~u) u = '1;
      else u = u + p[63:0];
    end
    return u ^ BIAS64;
  endfunction

  // Advance the class state by one detection and build the expected result
  function automatic out_t gate_predict(in_t it);
    out_t        r;
    int          c;
    logic [15:0] m;
    longint      x, y, mx, my, dx, dy, k, nx, ny, ex, ey;
    logic [63:0] lim;
    bit          report_now;
    r = '0;
    if (it.target_class < 1 || it.target_class > NUM_CLASSES) return r;
    c = it.target_class - 1;
    m = (gate_merge == 0) ? 16'd1 : 16'(gate_merge);
    x = longint'(it.pos_x);
    y = longint'(it.pos_y);
    r.status = ST_ACCEPTED;
    report_now = 1'b0;
    if (cls_cnt[c] == 0) begin
      cls_mx[c] = it.pos_x;
      cls_my[c] = it.pos_y;
      for (int i = 0; i < 4; i++) cls_sum[c*4+i] = '0;
      cls_cnt[c] = 16'd1;
      r.status = ST_FIRST;
    end else begin
      mx = longint'(signed'(cls_mx[c]));
      my = longint'(signed'(cls_my[c]));
      dx = x - mx;
      dy = y - my;
      if (cls_cnt[c] >= m && (z_exceeds(dx, cls_sum[c*4]) || z_exceeds(dy, cls_sum[c*4+3])))
      begin
        r.status = ST_OUTLIER;
        report_now = 1'b1;
      end else begin
        if (cls_cnt[c] != 16'hFFFF) cls_cnt[c] = cls_cnt[c] + 1'b1;
        k = longint'(cls_cnt[c]);
        nx = mx + dx / k;
        ny = my + dy / k;
        ex = x - nx;
        ey = y - ny;
        cls_mx[c] = nx[31:0];
        cls_my[c] = ny[31:0];
        cls_sum[c*4]   = sq_accum(cls_sum[c*4], dx, ex);
        cls_sum[c*4+1] = cross_accum(cls_sum[c*4+1], dx, ey);
        cls_sum[c*4+2] = cross_accum(cls_sum[c*4+2], dy, ex);
        cls_sum[c*4+3] = sq_accum(cls_sum[c*4+3], dy, ey);
        lim = (cls_cnt[c] <= m) ? 64'(gate_early) : 64'(gate_late);
        if (cls_sum[c*4] > lim || cls_sum[c*4+3] > lim) begin
          cls_cnt[c] = '0; cls_mx[c] = '0; cls_my[c] = '0;
          for (int i = 0; i < 4; i++) cls_sum[c*4+i] = '0;
          r.status = ST_RESET;
          report_now = 1'b1;
        end
      end
    end
    if (!report_now) begin
      // Slow-down request until the service accepts one, then snapshot with return-to-normal
      if (!cls_slow_sent[c] && cls_cnt[c] >= 16'(gate_slow)) begin
        r.slow_request = 1'b1;
        if (it.service_accepts) begin
          srch_active = 1'b1;
          srch_class = it.target_class[1:0];
          cls_slow_sent[c] = 1'b1;
        end
      end
      if (cls_cnt[c] % m == 0) begin
        r.snapshot_valid = 1'b1;
        if (srch_active && srch_class == it.target_class[1:0]) begin
          r.normal_request = 1'b1;
          if (it.service_accepts) srch_active = 1'b0;
        end
      end
    end
    r.class_out = it.target_class[1:0];
    r.mean_x = cls_mx[c];
    r.mean_y = cls_my[c];
    r.sum_xx = cls_sum[c*4][62:0];
    r.sum_xy = cls_sum[c*4+1];
    r.sum_yx = cls_sum[c*4+2];
    r.sum_yy = cls_sum[c*4+3][62:0];
    r.obs_count = cls_cnt[c];
    return r;
  endfunction

  // Driver: offer pending items, predict each at acceptance
  always @(posedge clk) begin
    out_t pred;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        pred = gate_predict(item);
        expected_results.insert(expected_results.size(), pred);
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic field_check(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, f, e, a);
      errors++;
    end
  endtask

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d class %0d", $time, result.status,
                 result.class_out);
        errors++;
      end else begin
        e = expected_results.pop_front();
        field_check("status", 64'(e.status), 64'(result.status));
        field_check("slow_request", 64'(e.slow_request), 64'(result.slow_request));
        field_check("normal_request", 64'(e.normal_request), 64'(result.normal_request));
        field_check("snapshot_valid", 64'(e.snapshot_valid), 64'(result.snapshot_valid));
        field_check("class_out", 64'(e.class_out), 64'(result.class_out));
        field_check("mean_x", 64'(e.mean_x), 64'(result.mean_x));
        field_check("mean_y", 64'(e.mean_y), 64'(result.mean_y));
        field_check("sum_xx", 64'(e.sum_xx), 64'(result.sum_xx));
        field_check("sum_xy", e.sum_xy, result.sum_xy);
        field_check("sum_yx", e.sum_yx, result.sum_yx);
        field_check("sum_yy", 64'(e.sum_yy), 64'(result.sum_yy));
        field_check("obs_count", 64'(e.obs_count), 64'(result.obs_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] cls, logic [31:0] x, logic [31:0] y, logic ok);
    in_t it;
    it.target_class = cls;
    it.pos_x = x;
    it.pos_y = y;
    it.service_accepts = ok;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Hold until every item is out, then let the back end drain
  task automatic drain;
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MERGE_COUNT:  gate_merge = val[7:0];
      REG_SLOW_COUNT:   gate_slow = val[7:0];
      REG_Z_LIMIT:      gate_z = val[15:0];
      REG_SPREAD_EARLY: gate_early = val[46:0];
      REG_SPREAD_LATE:  gate_late = val[46:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [7:0] m, logic [7:0] s, logic [15:0] z,
                          logic [46:0] e, logic [46:0] l);
    reg_write(REG_MERGE_COUNT, 64'(m));
    reg_write(REG_SLOW_COUNT, 64'(s));
    reg_write(REG_Z_LIMIT, 64'(z));
    reg_write(REG_SPREAD_EARLY, 64'(e));
    reg_write(REG_SPREAD_LATE, 64'(l));
  endtask

  // Random detections: mostly tight clusters per class, some jumps and noise
  task automatic random_items(int n);
    int got, r, c, amp;
    got = 0;
    while (got < n) begin
      r = $urandom_range(99);
      c = $urandom_range(NUM_CLASSES - 1);
      if (r < 8) begin
        push_item(8'($urandom_range(255)), $urandom, $urandom, 1'($urandom));
      end else if (r < 14) begin
        push_item(8'(c + 1), $urandom, $urandom, 1'($urandom));
        got++;
      end else begin
        if (r < 16) begin
          ctr_x[c] = int'($urandom);
          ctr_y[c] = int'($urandom);
        end
        amp = 1 << $urandom_range(2, 13);
        push_item(8'(c + 1), ctr_x[c] + $urandom_range(2*amp) - amp,
                  ctr_y[c] + $urandom_range(2*amp) - amp, 1'($urandom));
        got++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored classes, extreme positions, refused then granted slow-down
    send_idle = 31;
    push_item(8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_item(8'd4, $urandom, $urandom, 1'b1);
    push_item(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_item(8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_item(8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    push_item(8'd3, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    for (int i = 0; i < 6; i++)
      push_item(8'd2, 32'h0001_0000 + i, 32'h0002_0000 - i, 1'(i > 3));
    random_items(200);
    drain();

    // Lowest settings: every difference gates, every spread clears
    set_regs(8'd1, 8'd1, 16'd0, 47'd0, 47'd0);
    push_item(8'd1, 32'h0, 32'h0, 1'b1);
    push_item(8'd1, 32'h0, 32'h0, 1'b1);
    push_item(8'd1, 32'h1, 32'h0, 1'b1);
    push_item(8'd2, 32'h10, 32'h10, 1'b0);
    random_items(200);
    drain();

    // Highest settings
    send_idle = 49;
    set_regs(8'd255, 8'd255, 16'hFFFF, MAX47, MAX47);
    random_items(210);
    drain();

    // Zero merge count acts as one
    set_regs(8'd0, 8'd2, 16'd640, MAX47, 47'h1_0000_0000);
    random_items(210);
    drain();

    send_idle = 0;
    set_regs(8'($urandom_range(2, 10)), 8'($urandom_range(1, 8)),
             16'($urandom_range(256, 2000)), 47'(64'd1 << $urandom_range(28, 34)),
             47'(64'd1 << $urandom_range(34, 40)));
    random_items(210);
    drain();

    set_regs(8'd4, 8'd3, 16'd768, 47'h8000_0000, 47'h2_0000_0000);
    random_items(210);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== per_class_welford_outlier_gate_unit.f =====
rtl/pwog_pkg.sv
rtl/pwog_front.sv
rtl/pwog_queue.sv
rtl/pwog_back.sv
rtl/per_class_welford_outlier_gate_unit.sv
rtl/pwog_checker.sv
tb/per_class_welford_outlier_gate_unit_tb.sv
